// ----- src/arbb_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and saturation helper for the affine rectangle bounding box
// no dependencies; every other file imports this package

package arbb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;

  localparam int CW     = COORD_WIDTH;
  localparam int EXT_W  = CW + 1;   // one add of two coordinates
  localparam int SUM_W  = CW + 2;   // sum of three coordinates
  localparam int PROD_W = 2 * CW;   // exact product

  localparam int CFG_IDX_W = 3;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CW_MAX     = coord_t'({1'b0, {(CW-1){1'b1}}});
  localparam coord_t CW_MIN     = coord_t'({1'b1, {(CW-1){1'b0}}});
  localparam coord_t CW_NEG_MAX = coord_t'({1'b1, {(CW-2){1'b0}}, 1'b1});
  localparam coord_t FX_ONE     = coord_t'({{(CW-FRAC_BITS-1){1'b0}}, 1'b1,
                                            {FRAC_BITS{1'b0}}});

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_M_A     = 3'd0,
    REG_M_B     = 3'd1,
    REG_M_C     = 3'd2,
    REG_M_D     = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t rect_width;
    coord_t rect_height;
  } rect_item_t;

  typedef struct packed {
    coord_t box_x;
    coord_t box_y;
    coord_t box_width;
    coord_t box_height;
    logic   passed_through;
  } box_item_t;

  typedef struct packed {
    coord_t m_a;
    coord_t m_b;
    coord_t m_c;
    coord_t m_d;
    coord_t shift_x;
    coord_t shift_y;
  } matrix_t;

  // stage control traveling alongside the data
  typedef struct packed {
    logic valid;
    logic pass;
  } stage_ctl_t;

  // the two distinct x and y values among the four corners
  typedef struct packed {
    coord_t x0;
    coord_t x1;
    coord_t y0;
    coord_t y1;
  } corner_t;

  // scaled matrix terms, one per matrix entry and distinct coordinate
  typedef struct packed {
    coord_t ax0;
    coord_t ax1;
    coord_t cy0;
    coord_t cy1;
    coord_t bx0;
    coord_t bx1;
    coord_t dy0;
    coord_t dy1;
  } term_t;

  // clamp a sign-extended wide value into the coordinate range
  function automatic coord_t sat_coord(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-CW:0] hi_bits;
    hi_bits = v[PROD_W-1:CW-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return v[CW-1:0];
    end else if (v[PROD_W-1]) begin
      return CW_MIN;
    end else begin
      return CW_MAX;
    end
  endfunction

endpackage

// ----- src/arbb_rect_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for rectangles, boxes and register writes
// depends on arbb_pkg

interface arbb_rect_if import arbb_pkg::*; ();
  logic       valid;
  logic       ready;
  rect_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arbb_box_if import arbb_pkg::*; ();
  logic      valid;
  logic      ready;
  box_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arbb_cfg_if import arbb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  coord_t               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/affine_rect_bounding_box.sv -----
`timescale 1ns / 1ps
// top level of the affine rectangle bounding box pipeline
// depends on arbb_pkg, the channel interfaces, arbb_regs, arbb_corner, arbb_mul, arbb_reduce
//
// usage:
//   rect_in  - rectangle transactions (origin_x, origin_y, rect_width, rect_height), Q16.16
//   box_out  - box transactions (box_x, box_y, box_width, box_height, passed_through)
//   cfg      - register writes: index 0..5 = m_a, m_b, m_c, m_d, shift_x, shift_y;
//              always ready, writes to other indexes are dropped; write only while idle
//   rate     - one rectangle per cycle while box_out is not stalled; the whole six-stage
//              pipeline advances together, the eight 32x32 products sit in one stage
//   reset    - rst (synchronous) empties the pipeline and loads the identity matrix
//              with zero translation
//   stall    - while box_out holds a box that is not taken, every stage freezes and
//              rect_in.ready drops; nothing is lost or repeated. rect_in.ready also
//              stays high while a box waits, as long as the receiver takes it
//   marker   - an origin coordinate of +/- max passes the rectangle through unchanged
//              with passed_through set

module affine_rect_bounding_box import arbb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  arbb_cfg_if.sink    cfg,
  arbb_rect_if.sink   rect_in,
  arbb_box_if.source  box_out
);

  matrix_t    matrix;
  logic       advance;

  // stage 1 outputs
  stage_ctl_t corner_ctl;
  corner_t    corner;
  rect_item_t corner_raw;

  // stage 3 outputs
  stage_ctl_t term_ctl;
  term_t      term;
  rect_item_t term_raw;

  // whole pipeline moves when the output register is free or being drained
  assign advance       = !box_out.valid || box_out.ready;
  assign rect_in.ready = advance;

  arbb_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .matrix (matrix)
  );

  // stage 1: corner sums, marker check
  arbb_corner u_corner (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (rect_in.valid),
    .in_item  (rect_in.data),
    .ctl      (corner_ctl),
    .corner   (corner),
    .raw      (corner_raw)
  );

  // stages 2 and 3: products, floor shift with saturation
  arbb_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .matrix (matrix),
    .in_ctl (corner_ctl),
    .corner (corner),
    .in_raw (corner_raw),
    .ctl    (term_ctl),
    .term   (term),
    .raw    (term_raw)
  );

  // stages 4 to 6: extremes, translation, extents, output register
  arbb_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .matrix    (matrix),
    .in_ctl    (term_ctl),
    .term      (term),
    .in_raw    (term_raw),
    .out_valid (box_out.valid),
    .out_item  (box_out.data)
  );

  // a computed box never has a negative extent
  a_width_nonneg: assert property (@(posedge clk) disable iff (rst)
    (box_out.valid && !box_out.data.passed_through) |-> !box_out.data.box_width[CW-1])
    else $error("negative box width on computed box");

  a_height_nonneg: assert property (@(posedge clk) disable iff (rst)
    (box_out.valid && !box_out.data.passed_through) |-> !box_out.data.box_height[CW-1])
    else $error("negative box height on computed box");

  // reset must empty the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !box_out.valid)
    else $error("box transaction offered right after reset");

  // once the pipeline has advanced through all its stages with no rectangle accepted, nothing can come out
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (advance && !(rect_in.valid && rect_in.ready)) ##1
    (advance && !(rect_in.valid && rect_in.ready)) ##1
    (advance && !(rect_in.valid && rect_in.ready)) ##1
    (advance && !(rect_in.valid && rect_in.ready)) ##1
    (advance && !(rect_in.valid && rect_in.ready)) ##1
    (advance && !(rect_in.valid && rect_in.ready)) |=> !box_out.valid)
    else $error("box transaction without a matching rectangle");

endmodule

// ----- src/arbb_regs.sv -----
`timescale 1ns / 1ps
// affine matrix and translation registers, written through the config channel
// depends on arbb_pkg and arbb_cfg_if

module arbb_regs import arbb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  arbb_cfg_if.sink        cfg,
  output matrix_t         matrix
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix.m_a     <= FX_ONE;
      matrix.m_b     <= '0;
      matrix.m_c     <= '0;
      matrix.m_d     <= FX_ONE;
      matrix.shift_x <= '0;
      matrix.shift_y <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_M_A:     matrix.m_a     <= cfg.data;
        REG_M_B:     matrix.m_b     <= cfg.data;
        REG_M_C:     matrix.m_c     <= cfg.data;
        REG_M_D:     matrix.m_d     <= cfg.data;
        REG_SHIFT_X: matrix.shift_x <= cfg.data;
        REG_SHIFT_Y: matrix.shift_y <= cfg.data;
        default:     ; // unused indexes are dropped
      endcase
    end
  end

endmodule

// ----- src/arbb_corner.sv -----
`timescale 1ns / 1ps
// first pipeline stage: far corner sums and marker origin detection
// depends on arbb_pkg

module arbb_corner import arbb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  rect_item_t in_item,
  output stage_ctl_t ctl,
  output corner_t    corner,
  output rect_item_t raw
);

  logic   marker;
  coord_t far_x;
  coord_t far_y;

  always_comb begin
    marker = (in_item.origin_x == CW_MAX) || (in_item.origin_x == CW_NEG_MAX) ||
             (in_item.origin_y == CW_MAX) || (in_item.origin_y == CW_NEG_MAX);
    far_x  = sat_coord(PROD_W'(EXT_W'(in_item.origin_x) + EXT_W'(in_item.rect_width)));
    far_y  = sat_coord(PROD_W'(EXT_W'(in_item.origin_y) + EXT_W'(in_item.rect_height)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.pass  <= marker;
      corner.x0 <= in_item.origin_x;
      corner.x1 <= far_x;
      corner.y0 <= in_item.origin_y;
      corner.y1 <= far_y;
      raw       <= in_item;
    end
  end

endmodule

// ----- src/arbb_mul.sv -----
`timescale 1ns / 1ps
// two pipeline stages: exact matrix products, then floor shift and saturation
// depends on arbb_pkg

module arbb_mul import arbb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  matrix_t    matrix,
  input  stage_ctl_t in_ctl,
  input  corner_t    corner,
  input  rect_item_t in_raw,
  output stage_ctl_t ctl,
  output term_t      term,
  output rect_item_t raw
);

  typedef logic signed [PROD_W-1:0] prod_t;

  stage_ctl_t prod_ctl;
  rect_item_t prod_raw;
  prod_t      p_ax0, p_ax1, p_cy0, p_cy1, p_bx0, p_bx1, p_dy0, p_dy1;

  // product stage: eight signed multiplies, one per term
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl.valid <= 1'b0;
    end else if (en) begin
      prod_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ctl.pass <= in_ctl.pass;
      prod_raw      <= in_raw;
      p_ax0 <= PROD_W'(matrix.m_a) * PROD_W'(corner.x0);
      p_ax1 <= PROD_W'(matrix.m_a) * PROD_W'(corner.x1);
      p_cy0 <= PROD_W'(matrix.m_c) * PROD_W'(corner.y0);
      p_cy1 <= PROD_W'(matrix.m_c) * PROD_W'(corner.y1);
      p_bx0 <= PROD_W'(matrix.m_b) * PROD_W'(corner.x0);
      p_bx1 <= PROD_W'(matrix.m_b) * PROD_W'(corner.x1);
      p_dy0 <= PROD_W'(matrix.m_d) * PROD_W'(corner.y0);
      p_dy1 <= PROD_W'(matrix.m_d) * PROD_W'(corner.y1);
    end
  end

  // scale stage: arithmetic shift rounds toward minus infinity
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= prod_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.pass <= prod_ctl.pass;
      raw      <= prod_raw;
      term.ax0 <= sat_coord(p_ax0 >>> FRAC_BITS);
      term.ax1 <= sat_coord(p_ax1 >>> FRAC_BITS);
      term.cy0 <= sat_coord(p_cy0 >>> FRAC_BITS);
      term.cy1 <= sat_coord(p_cy1 >>> FRAC_BITS);
      term.bx0 <= sat_coord(p_bx0 >>> FRAC_BITS);
      term.bx1 <= sat_coord(p_bx1 >>> FRAC_BITS);
      term.dy0 <= sat_coord(p_dy0 >>> FRAC_BITS);
      term.dy1 <= sat_coord(p_dy1 >>> FRAC_BITS);
    end
  end

endmodule

// ----- src/arbb_reduce.sv -----
`timescale 1ns / 1ps
// three pipeline stages: term min/max, translated extremes, extents and output register
// depends on arbb_pkg

module arbb_reduce import arbb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  matrix_t    matrix,
  input  stage_ctl_t in_ctl,
  input  term_t      term,
  input  rect_item_t in_raw,
  output logic       out_valid,
  output box_item_t  out_item
);

  stage_ctl_t mm_ctl, ext_ctl;
  rect_item_t mm_raw, ext_raw;
  coord_t     min_a, max_a, min_c, max_c, min_b, max_b, min_d, max_d;
  coord_t     min_x, max_x, min_y, max_y;

  // each mapped coordinate splits into two independent terms, so the
  // corner extremes are sums of the per-term extremes
  always_ff @(posedge clk) begin
    if (rst) begin
      mm_ctl.valid  <= 1'b0;
      ext_ctl.valid <= 1'b0;
      out_valid     <= 1'b0;
    end else if (en) begin
      mm_ctl.valid  <= in_ctl.valid;
      ext_ctl.valid <= mm_ctl.valid;
      out_valid     <= ext_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm_ctl.pass <= in_ctl.pass;
      mm_raw      <= in_raw;
      min_a <= (term.ax0 < term.ax1) ? term.ax0 : term.ax1;
      max_a <= (term.ax0 < term.ax1) ? term.ax1 : term.ax0;
      min_c <= (term.cy0 < term.cy1) ? term.cy0 : term.cy1;
      max_c <= (term.cy0 < term.cy1) ? term.cy1 : term.cy0;
      min_b <= (term.bx0 < term.bx1) ? term.bx0 : term.bx1;
      max_b <= (term.bx0 < term.bx1) ? term.bx1 : term.bx0;
      min_d <= (term.dy0 < term.dy1) ? term.dy0 : term.dy1;
      max_d <= (term.dy0 < term.dy1) ? term.dy1 : term.dy0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ext_ctl.pass <= mm_ctl.pass;
      ext_raw      <= mm_raw;
      min_x <= sat_coord(PROD_W'(SUM_W'(min_a) + SUM_W'(min_c) + SUM_W'(matrix.shift_x)));
      max_x <= sat_coord(PROD_W'(SUM_W'(max_a) + SUM_W'(max_c) + SUM_W'(matrix.shift_x)));
      min_y <= sat_coord(PROD_W'(SUM_W'(min_b) + SUM_W'(min_d) + SUM_W'(matrix.shift_y)));
      max_y <= sat_coord(PROD_W'(SUM_W'(max_b) + SUM_W'(max_d) + SUM_W'(matrix.shift_y)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ext_ctl.pass) begin
        out_item.box_x          <= ext_raw.origin_x;
        out_item.box_y          <= ext_raw.origin_y;
        out_item.box_width      <= ext_raw.rect_width;
        out_item.box_height     <= ext_raw.rect_height;
        out_item.passed_through <= 1'b1;
      end else begin
        out_item.box_x          <= min_x;
        out_item.box_y          <= min_y;
        out_item.box_width      <= sat_coord(PROD_W'(EXT_W'(max_x) - EXT_W'(min_x)));
        out_item.box_height     <= sat_coord(PROD_W'(EXT_W'(max_y) - EXT_W'(min_y)));
        out_item.passed_through <= 1'b0;
      end
    end
  end

endmodule

// ----- dv/tb_affine_rect_bounding_box.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the affine rectangle bounding box: directed rows, then random
// rectangles under several matrix settings with random stalls; needs arbb_pkg, the channel
// interfaces and affine_rect_bounding_box

module tb_affine_rect_bounding_box;
  import arbb_pkg::*;

  // writes to these indexes must leave the matrix alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int PHASES     = 8;
  localparam int PHASE_RECT = 190;  // random rectangles per matrix setting
  localparam int LONG_HOLD  = 80;   // receiver hold-off, far beyond the pipeline depth
  localparam int DRAIN_WAIT = 12;   // idle wait after the drain, well beyond the pipeline depth

  // one row of the directed stimulus; typed rows carry their own box
  typedef struct {
    rect_item_t rect;
    bit         typed;
    box_item_t  want;
  } plan_row_t;

  logic clk;
  logic rst;

  arbb_cfg_if  cfg_bus ();
  arbb_rect_if rect_bus ();
  arbb_box_if  box_bus ();

  affine_rect_bounding_box u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .rect_in (rect_bus),
    .box_out (box_bus)
  );

  // predictor copy of the matrix registers, reset value is identity with no translation
  matrix_t   gain = '{m_a: FX_ONE, m_b: '0, m_c: '0, m_d: FX_ONE, shift_x: '0, shift_y: '0};
  box_item_t boxes_due [$];   // boxes owed by the block, oldest first
  plan_row_t plan [$];
  int        mismatches = 0;
  bit        stall_req  = 1'b0;
  bit        sink_calm  = 1'b0;

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------

  // clamp into the signed coordinate range
  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(CW_MAX)) return CW_MAX;
    if (v < longint'(CW_MIN)) return CW_MIN;
    return coord_t'(v);
  endfunction

  // exact product, floor shift by the fraction bits, then clamp
  function automatic longint scaled_term(input coord_t k, input coord_t c);
    longint p;
    p = longint'(k) * longint'(c);
    return longint'(clamp_coord(p >>> FRAC_BITS));
  endfunction

  // box of the four mapped corners, or the rectangle itself for a marker origin
  function automatic box_item_t bound_box(input matrix_t m, input rect_item_t r);
    box_item_t b;
    coord_t    xs [2];
    coord_t    ys [2];
    coord_t    px, py, minx, maxx, miny, maxy;
    if (r.origin_x == CW_MAX || r.origin_x == CW_NEG_MAX ||
        r.origin_y == CW_MAX || r.origin_y == CW_NEG_MAX) begin
      b.box_x          = r.origin_x;
      b.box_y          = r.origin_y;
      b.box_width      = r.rect_width;
      b.box_height     = r.rect_height;
      b.passed_through = 1'b1;
      return b;
    end
    xs[0] = r.origin_x;
    xs[1] = clamp_coord(longint'(r.origin_x) + longint'(r.rect_width));
    ys[0] = r.origin_y;
    ys[1] = clamp_coord(longint'(r.origin_y) + longint'(r.rect_height));
    minx = CW_MAX; maxx = CW_MIN; miny = CW_MAX; maxy = CW_MIN;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        px = clamp_coord(scaled_term(m.m_a, xs[i]) + scaled_term(m.m_c, ys[j]) +
                         longint'(m.shift_x));
        py = clamp_coord(scaled_term(m.m_b, xs[i]) + scaled_term(m.m_d, ys[j]) +
                         longint'(m.shift_y));
        if (px < minx) minx = px;
        if (px > maxx) maxx = px;
        if (py < miny) miny = py;
        if (py > maxy) maxy = py;
      end
    end
    b.box_x          = minx;
    b.box_y          = miny;
    b.box_width      = clamp_coord(longint'(maxx) - longint'(minx));
    b.box_height     = clamp_coord(longint'(maxy) - longint'(miny));
    b.passed_through = 1'b0;
    return b;
  endfunction

  // ---------------------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------------------

  // uniform value in [-r, r]
  function automatic coord_t span(input int unsigned r);
    return coord_t'(int'($urandom_range(2 * r, 0)) - int'(r));
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // coordinate mix: small and mid magnitudes, full-range bits, and the extremes
  function automatic coord_t rand_coord();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return span(1 << 24);
      4, 5:       return coord_t'($urandom);
      6: begin
        case ($urandom_range(4, 0))
          0:       return CW_MAX;
          1:       return CW_MIN;
          2:       return CW_NEG_MAX;
          3:       return '0;
          default: return '1;
        endcase
      end
      7:       return span(1 << 16);
      default: return span(1 << 28);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------------------

  task automatic add_row(input coord_t x, input coord_t y, input coord_t w, input coord_t h,
                         input bit typed, input coord_t bx, input coord_t by,
                         input coord_t bw, input coord_t bh, input logic pt);
    plan_row_t row;
    row.rect  = '{origin_x: x, origin_y: y, rect_width: w, rect_height: h};
    row.typed = typed;
    row.want  = '{box_x: bx, box_y: by, box_width: bw, box_height: bh, passed_through: pt};
    plan.push_back(row);
  endtask

  // offer one rectangle, record what it owes once the transaction happens
  task automatic send_rect(input rect_item_t r, input int gap, input bit typed,
                           input box_item_t want);
    if (gap > 0) begin
      rect_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rect_bus.valid <= 1'b1;
    rect_bus.data  <= r;
    do @(posedge clk); while (!rect_bus.ready);
    boxes_due.push_back(typed ? want : bound_box(gain, r));
  endtask

  // stop offering and wait until every owed box has come back
  task automatic wait_drained();
    rect_bus.valid <= 1'b0;
    do @(posedge clk); while (boxes_due.size() != 0);
  endtask

  // write all six matrix registers, optionally followed by writes to unused indexes
  task automatic load_matrix(input coord_t ent [6], input bit spare);
    logic [CFG_IDX_W-1:0] idx [$];
    coord_t               val [$];
    idx = '{REG_M_A, REG_M_B, REG_M_C, REG_M_D, REG_SHIFT_X, REG_SHIFT_Y};
    val = '{ent[REG_M_A], ent[REG_M_B], ent[REG_M_C], ent[REG_M_D],
            ent[REG_SHIFT_X], ent[REG_SHIFT_Y]};
    if (spare) begin
      idx.push_back(REG_SPARE_LO);
      val.push_back(coord_t'($urandom));
      idx.push_back(REG_SPARE_HI);
      val.push_back(coord_t'($urandom));
    end
    for (int k = 0; k < idx.size(); k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      do @(posedge clk); while (!cfg_bus.ready);
      case (idx[k])
        REG_M_A:     gain.m_a     = val[k];
        REG_M_B:     gain.m_b     = val[k];
        REG_M_C:     gain.m_c     = val[k];
        REG_M_D:     gain.m_d     = val[k];
        REG_SHIFT_X: gain.shift_x = val[k];
        REG_SHIFT_Y: gain.shift_y = val[k];
        default:     ;  // unused index, dropped by the block
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // box receiver: random hold-offs, calm stretches, one long hold on request
  // ---------------------------------------------------------------------------------------

  initial begin : box_sink
    int n;
    int loops;
    bit held;
    box_bus.ready <= 1'b0;
    loops = 0;
    do @(posedge clk); while (rst);
    forever begin
      loops++;
      if (loops % 50 == 0) sink_calm = ($urandom_range(3, 0) == 0);
      held = stall_req;
      n    = held ? LONG_HOLD : pick_gap(sink_calm);
      if (n > 0) begin
        box_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      box_bus.ready <= 1'b1;
      @(posedge clk);
      if (held) stall_req = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // checker: every box transaction against the oldest owed box
  // ---------------------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [CW-1:0] want,
                             input logic [CW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    box_item_t want;
    box_item_t got;
    if (!rst && box_bus.valid && box_bus.ready) begin
      got = box_bus.data;
      if (boxes_due.size() == 0) begin
        mismatches++;
        $display("%0t: box with nothing owed, expected none, actual %h", $time, got);
      end else begin
        want = boxes_due.pop_front();
        check_field("box_x", want.box_x, got.box_x);
        check_field("box_y", want.box_y, got.box_y);
        check_field("box_width", want.box_width, got.box_width);
        check_field("box_height", want.box_height, got.box_height);
        check_field("passed_through", CW'(want.passed_through), CW'(got.passed_through));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------------

  initial begin : stimulus
    coord_t     ent [6];
    rect_item_t r;
    box_item_t  none;
    int         gap;
    int         burst;
    bit         calm;

    // every input known from time zero, reset held high at the start
    rst            <= 1'b1;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= REG_M_A;
    cfg_bus.data   <= '0;
    rect_bus.valid <= 1'b0;
    rect_bus.data  <= '0;
    none  = '0;
    burst = 0;
    calm  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows under the reset matrix (identity, no translation)
    // plain rectangle, zero rectangle
    add_row('0, '0, '0, '0, 1, '0, '0, '0, '0, 1'b0);
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
            1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1'b0);
    // negative sizes flip the box, extents stay positive
    add_row(32'h000A_0000, 32'h000A_0000, 32'hFFFC_0000, 32'hFFFA_0000,
            1, 32'h0006_0000, 32'h0004_0000, 32'h0004_0000, 32'h0006_0000, 1'b0);
    // marker origins in each coordinate and sign pass the rectangle through
    add_row(CW_MAX, 32'h0000_0005, 32'h0000_0007, 32'h0000_0009,
            1, CW_MAX, 32'h0000_0005, 32'h0000_0007, 32'h0000_0009, 1'b1);
    add_row(CW_NEG_MAX, 32'h1234_5678, CW_MIN, CW_MAX,
            1, CW_NEG_MAX, 32'h1234_5678, CW_MIN, CW_MAX, 1'b1);
    add_row(32'h0001_0000, CW_MAX, CW_MAX, CW_MIN,
            1, 32'h0001_0000, CW_MAX, CW_MAX, CW_MIN, 1'b1);
    add_row(CW_MIN, CW_NEG_MAX, '1, '0, 1, CW_MIN, CW_NEG_MAX, '1, '0, 1'b1);
    // most negative origin is not a marker
    add_row(CW_MIN, CW_MIN, '0, '0, 1, CW_MIN, CW_MIN, '0, '0, 1'b0);
    // just inside the marker values
    add_row(32'h8000_0002, 32'h7FFF_FFFD, 32'h0000_0001, 32'h0000_0002,
            1, 32'h8000_0002, 32'h7FFF_FFFD, 32'h0000_0001, 32'h0000_0002, 1'b0);
    // corner sums clamp at the top and bottom
    add_row(32'h7FFF_FFFE, 32'h7FFF_FFFE, CW_MAX, CW_MAX,
            1, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h0000_0001, 32'h0000_0001, 1'b0);
    add_row(CW_MIN, '0, CW_MIN, '0, 1, CW_MIN, '0, '0, '0, 1'b0);
    add_row(CW_MIN, CW_MIN, '1, '1, 1, CW_MIN, CW_MIN, '0, '0, 1'b0);
    // full-range extents, one of them clamps
    add_row(CW_MIN, CW_MIN, CW_MAX, CW_MAX, 1, CW_MIN, CW_MIN, CW_MAX, CW_MAX, 1'b0);
    add_row('0, '0, CW_MAX, CW_MIN, 1, '0, CW_MIN, CW_MAX, CW_MAX, 1'b0);
    // all ones: floor shift keeps minus one exact
    add_row('1, '1, '1, '1, 1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'h0000_0001,
            32'h0000_0001, 1'b0);
    // alternating bit patterns and fractions, left to the predictor
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            0, '0, '0, '0, '0, 1'b0);
    add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
            0, '0, '0, '0, '0, 1'b0);
    add_row(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF,
            0, '0, '0, '0, '0, 1'b0);
    add_row(32'h7FFF_0000, 32'h8001_0000, 32'h0100_0000, 32'hFF00_0000,
            0, '0, '0, '0, '0, 1'b0);

    foreach (plan[i]) send_rect(plan[i].rect, pick_gap(1'b0), plan[i].typed, plan[i].want);

    // random phases, each under its own matrix, loaded only once the pipe is empty
    for (int ph = 1; ph <= PHASES; ph++) begin
      wait_drained();
      case (ph)
        1: begin  // modest scale and shear
          ent[REG_M_A]     = span(1 << 18);
          ent[REG_M_B]     = span(1 << 16);
          ent[REG_M_C]     = span(1 << 16);
          ent[REG_M_D]     = span(1 << 18);
          ent[REG_SHIFT_X] = span(1 << 26);
          ent[REG_SHIFT_Y] = span(1 << 26);
        end
        2: foreach (ent[k]) ent[k] = CW_MAX;
        3: foreach (ent[k]) ent[k] = CW_MIN;
        4: begin  // everything collapses onto the translation
          foreach (ent[k]) ent[k] = '0;
          ent[REG_SHIFT_X] = CW_MAX;
          ent[REG_SHIFT_Y] = CW_MIN;
        end
        5: foreach (ent[k]) ent[k] = coord_t'($urandom);
        6: begin  // rotation-like: b and c of opposite sign
          ent[REG_M_A]     = span(1 << 16);
          ent[REG_M_D]     = ent[REG_M_A];
          ent[REG_M_B]     = span(1 << 16);
          ent[REG_M_C]     = -ent[REG_M_B];
          ent[REG_SHIFT_X] = span(1 << 20);
          ent[REG_SHIFT_Y] = span(1 << 20);
        end
        7: begin  // identity again, spare writes must not disturb it
          foreach (ent[k]) ent[k] = '0;
          ent[REG_M_A]     = FX_ONE;
          ent[REG_M_D]     = FX_ONE;
          ent[REG_SHIFT_X] = span(1 << 20);
          ent[REG_SHIFT_Y] = span(1 << 20);
        end
        default: begin  // each entry drawn from the notable values
          foreach (ent[k]) begin
            case ($urandom_range(5, 0))
              0:       ent[k] = '0;
              1:       ent[k] = CW_MAX;
              2:       ent[k] = CW_MIN;
              3:       ent[k] = FX_ONE;
              4:       ent[k] = -FX_ONE;
              default: ent[k] = coord_t'($urandom);
            endcase
          end
        end
      endcase
      load_matrix(ent, ph == 2 || ph == 7);

      for (int n = 0; n < PHASE_RECT; n++) begin
        if (n % 64 == 0) calm = ($urandom_range(3, 0) == 0);
        // long receiver hold while the sender keeps offering back to back
        if (ph == 3 && n == 40) begin
          stall_req = 1'b1;
          burst     = 100;
        end
        // sender pauses mid-phase until every box is home
        if (ph == 5 && n == 95) wait_drained();
        gap = (burst > 0) ? 0 : pick_gap(calm);
        if (burst > 0) burst--;
        r.origin_x    = rand_coord();
        r.origin_y    = rand_coord();
        r.rect_width  = rand_coord();
        r.rect_height = rand_coord();
        send_rect(r, gap, 1'b0, none);
      end
    end

    // let the last boxes arrive, then watch for strays
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_affine_rect_bounding_box: done, clean");
    end else begin
      $display("tb_affine_rect_bounding_box: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("tb_affine_rect_bounding_box: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
src/arbb_pkg.sv
src/arbb_rect_if.sv
src/arbb_regs.sv
src/arbb_corner.sv
src/arbb_mul.sv
src/arbb_reduce.sv
src/affine_rect_bounding_box.sv
dv/tb_affine_rect_bounding_box.sv
